### sv/lsp_pkg.sv
package lsp_pkg;

  localparam int unsigned RangeW  = 20;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned CellW   = 24;
  localparam int unsigned DistW   = 25;
  localparam int unsigned VecW    = 34;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned GainW   = 30;
  localparam int unsigned StepCnt = 16;
  localparam int unsigned IterW   = 4;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [RangeW:0]  RANGE_MARGIN = 21'd410;
  localparam logic [GainW-1:0] INV_GAIN     = 30'd652032874;
  localparam logic [RangeW-1:0] MAX_RANGE_RST = 20'hFFFFF;
  localparam logic [ScaleW-1:0] SCALE_RST     = 24'd2621440;

  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3,
    REG_SCALE       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RangeW-1:0] range_sample;
    logic              first_beam;
    logic              last_beam;
  } in_beat_t;

  typedef struct packed {
    logic                    kept;
    logic signed [CellW-1:0] x_cells;
    logic signed [CellW-1:0] y_cells;
    logic                    scan_end;
  } out_beat_t;

  typedef struct packed {
    logic [AngleW-1:0] start_angle;
    logic [AngleW-1:0] angle_step;
    logic [RangeW-1:0] min_range;
    logic [RangeW-1:0] max_range;
    logic [ScaleW-1:0] cells_per_metre;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             scale;
    logic             gain;
    logic             rotate;
    logic             finish;
    logic [IterW-1:0] iter;
  } lsp_cmd_t;

  function automatic logic signed [PhaseW-1:0] atan_lut(input logic [IterW-1:0] i);
    logic signed [PhaseW-1:0] v;
    unique case (i)
      4'd0:  v = 32'sd536870912;
      4'd1:  v = 32'sd316933406;
      4'd2:  v = 32'sd167458907;
      4'd3:  v = 32'sd85004756;
      4'd4:  v = 32'sd42667331;
      4'd5:  v = 32'sd21354465;
      4'd6:  v = 32'sd10679838;
      4'd7:  v = 32'sd5340245;
      4'd8:  v = 32'sd2670163;
      4'd9:  v = 32'sd1335087;
      4'd10: v = 32'sd667544;
      4'd11: v = 32'sd333772;
      4'd12: v = 32'sd166886;
      4'd13: v = 32'sd83443;
      4'd14: v = 32'sd41722;
      default: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage

### sv/lsp_ctrl.sv
module lsp_ctrl
  import lsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lsp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_GAIN,
    S_ROT,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [IterW-1:0] iter_r;
  logic             out_valid_r;
  logic             emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.scale  = (state_r == S_SCALE);
    cmd.gain   = (state_r == S_GAIN);
    cmd.rotate = (state_r == S_ROT);
    cmd.finish = emit;
    cmd.iter   = iter_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: state_r <= S_GAIN;
        S_GAIN: begin
          iter_r  <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          iter_r <= iter_r + 1'b1;
          if (iter_r == IterW'(StepCnt - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/lsp_dp.sv
module lsp_dp
  import lsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  lsp_cmd_t  cmd,
  input  in_beat_t  in_data,
  output out_beat_t out_data
);

  logic [AngleW-1:0]        beam_r;
  logic [AngleW-1:0]        ang_r;
  logic [RangeW-1:0]        rng_r;
  logic                     keep_r;
  logic                     last_r;
  logic [DistW-1:0]         d_r;
  logic signed [VecW-1:0]   x_r;
  logic signed [VecW-1:0]   y_r;
  logic signed [PhaseW-1:0] z_r;
  logic [1:0]               q_r;
  out_beat_t                out_r;

  logic [AngleW-1:0]        a_sel;
  logic                     gate;
  logic [RangeW+ScaleW-1:0] prod_m;
  logic [RangeW+ScaleW:0]   prod_s;
  logic [DistW+GainW-1:0]   prod_g;
  logic [AngleW-1:0]        sh;
  logic signed [AngleW-2:0] resid;
  logic signed [VecW-1:0]   dx;
  logic signed [VecW-1:0]   dy;
  logic signed [PhaseW-1:0] at;
  logic signed [VecW-1:0]   rx;
  logic signed [VecW-1:0]   ry;
  logic signed [CellW-1:0]  xs;
  logic signed [CellW-1:0]  ys;

  function automatic logic signed [CellW-1:0] finish_val(input logic signed [VecW-1:0] v);
    logic signed [VecW-1:0] t;
    t = (v + VecW'(32)) >>> 6;
    if (t > VecW'(8388607)) begin
      return 24'sh7FFFFF;
    end else if (t < -VecW'(8388608)) begin
      return 24'sh800000;
    end
    return t[CellW-1:0];
  endfunction

  assign out_data = out_r;

  always_comb begin
    a_sel  = in_data.first_beam ? cfg.start_angle : beam_r;
    gate   = (in_data.range_sample > cfg.min_range) &&
             (({1'b0, in_data.range_sample} + RANGE_MARGIN) < {1'b0, cfg.max_range});
    prod_m = rng_r * cfg.cells_per_metre;
    prod_s = {1'b0, prod_m} + (RangeW+ScaleW+1)'(1 << 19);
    prod_g = d_r * INV_GAIN;
    sh     = ang_r + 16'h2000;
    resid  = $signed({1'b0, sh[13:0]}) - 15'sh2000;
    dx     = y_r >>> cmd.iter;
    dy     = x_r >>> cmd.iter;
    at     = atan_lut(cmd.iter);
    case (q_r)
      2'd0: begin
        rx = x_r;
        ry = y_r;
      end
      2'd1: begin
        rx = -y_r;
        ry = x_r;
      end
      2'd2: begin
        rx = -x_r;
        ry = -y_r;
      end
      default: begin
        rx = y_r;
        ry = -x_r;
      end
    endcase
    xs = finish_val(rx);
    ys = finish_val(ry);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_r <= '0;
    end else if (cmd.load) begin
      beam_r <= a_sel + cfg.angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_r  <= a_sel;
      rng_r  <= in_data.range_sample;
      keep_r <= gate;
      last_r <= in_data.last_beam;
    end
    if (cmd.scale) begin
      d_r <= prod_s[RangeW+ScaleW:20];
    end
    if (cmd.gain) begin
      x_r <= VecW'(prod_g[DistW+GainW-1:24]);
      y_r <= '0;
      z_r <= PhaseW'(resid) <<< 16;
      q_r <= sh[15:14];
    end
    if (cmd.rotate) begin
      if (!z_r[PhaseW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (cmd.finish) begin
      out_r.kept     <= keep_r;
      out_r.x_cells  <= keep_r ? xs : '0;
      out_r.y_cells  <= keep_r ? ys : '0;
      out_r.scan_end <= last_r;
    end
  end

endmodule

### sv/laser_scan_polar_to_cartesian_core.sv
// Channel  Ports                          Beat
// in       in_valid in_ready in_data       range_sample, first_beam, last_beam
// out      out_valid out_ready out_data    kept, x_cells, y_cells, scan_end
// cfg      psel penable pwrite paddr ...   start_angle .. cells_per_metre at 4*i
//
// Per item: accept, scale multiply, gain multiply, 16 CORDIC iterations on one
// shared shift-add unit, then output load; no new item is accepted until then.
// Reset (rst_n low, synchronous) clears beam angle, config registers and handshakes.
// The output register holds a finished beat while the next item is accepted;
// a stalled output holds the core in its last state until the beat is taken.
module laser_scan_polar_to_cartesian_core
  import lsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t     cfg_r;
  lsp_cmd_t cmd;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle     <= '0;
      cfg_r.angle_step      <= '0;
      cfg_r.min_range       <= '0;
      cfg_r.max_range       <= MAX_RANGE_RST;
      cfg_r.cells_per_metre <= SCALE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_ANGLE: cfg_r.start_angle     <= pwdata[AngleW-1:0];
        REG_ANGLE_STEP:  cfg_r.angle_step      <= pwdata[AngleW-1:0];
        REG_MIN_RANGE:   cfg_r.min_range       <= pwdata[RangeW-1:0];
        REG_MAX_RANGE:   cfg_r.max_range       <= pwdata[RangeW-1:0];
        REG_SCALE:       cfg_r.cells_per_metre <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_ANGLE: prdata = DataW'(cfg_r.start_angle);
      REG_ANGLE_STEP:  prdata = DataW'(cfg_r.angle_step);
      REG_MIN_RANGE:   prdata = DataW'(cfg_r.min_range);
      REG_MAX_RANGE:   prdata = DataW'(cfg_r.max_range);
      REG_SCALE:       prdata = DataW'(cfg_r.cells_per_metre);
      default:         prdata = '0;
    endcase
  end

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lsp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsp_pkg::*;

  localparam int          MARGIN_Q12    = 410;
  localparam longint      HALF_Q20      = 64'd1 << 19;
  localparam longint      GAIN_COMP_Q30 = 652032874;
  localparam longint      CELL_MAX      = 8388607;
  localparam longint      CELL_MIN      = -8388608;
  localparam logic [2:0]  REG_SPARE     = 3'd7;
  localparam int          IDLE_PCT      = 29;
  localparam int          PHASES        = 6;
  localparam int          PHASE_BEATS   = 190;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 3000;

  typedef struct packed {
    logic       is_write;
    logic [2:0] sel;
    logic [31:0] wdata;
    in_beat_t   beat;
    logic       fixed;
    out_beat_t  want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic      in_fixed = 1'b0;
  out_beat_t in_fixed_beat = '0;

  cfg_t              shadow;
  logic [AngleW-1:0] beam_angle;
  out_beat_t         pending[$];
  plan_row_t         plan[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;
  bit                sender_calm = 1'b0;
  bit                hold_request = 1'b0;

  longint arctan_q32 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  laser_scan_polar_to_cartesian_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic signed [CellW-1:0] to_cells(longint v);
    longint r;
    r = (v + 32) >>> 6;
    if (r > CELL_MAX) r = CELL_MAX;
    if (r < CELL_MIN) r = CELL_MIN;
    return r[CellW-1:0];
  endfunction

  function automatic out_beat_t project_beam(logic [AngleW-1:0] ang, in_beat_t b, cfg_t c);
    out_beat_t         r;
    logic [AngleW-1:0] sh;
    longint            span, x, y, z, dx, dy, rx, ry;
    r = '0;
    r.scan_end = b.last_beam;
    if (int'(b.range_sample) <= int'(c.min_range) ||
        int'(b.range_sample) + MARGIN_Q12 >= int'(c.max_range)) return r;
    r.kept = 1'b1;
    span = (longint'(b.range_sample) * longint'(c.cells_per_metre) + HALF_Q20) >>> 20;
    sh = ang + 16'h2000;
    z = (longint'(sh[13:0]) - 8192) * 65536;
    x = (span * GAIN_COMP_Q30) >>> 24;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q32[i];
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q32[i];
      end
    end
    case (sh[15:14])
      2'd0: begin rx = x;  ry = y;  end
      2'd1: begin rx = -y; ry = x;  end
      2'd2: begin rx = -x; ry = -y; end
      default: begin rx = y; ry = -x; end
    endcase
    r.x_cells = to_cells(rx);
    r.y_cells = to_cells(ry);
    return r;
  endfunction

  function automatic void check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [AngleW-1:0] ang;
    out_beat_t         want;
    out_beat_t         got;
    if (!rst_n) begin
      shadow.start_angle     = '0;
      shadow.angle_step      = '0;
      shadow.min_range       = '0;
      shadow.max_range       = 20'hFFFFF;
      shadow.cells_per_metre = 24'd2621440;
      beam_angle             = '0;
      pending.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_START_ANGLE: shadow.start_angle     = pwdata[AngleW-1:0];
          REG_ANGLE_STEP:  shadow.angle_step      = pwdata[AngleW-1:0];
          REG_MIN_RANGE:   shadow.min_range       = pwdata[RangeW-1:0];
          REG_MAX_RANGE:   shadow.max_range       = pwdata[RangeW-1:0];
          REG_SCALE:       shadow.cells_per_metre = pwdata[ScaleW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ang = in_data.first_beam ? shadow.start_angle : beam_angle;
        beam_angle = ang + shadow.angle_step;
        want = in_fixed ? in_fixed_beat : project_beam(ang, in_data, shadow);
        pending = {pending, want};
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending.size() == 0) begin
          $error("out beat with no result pending");
          mismatches++;
        end else begin
          want = pending.pop_front();
          check_field("kept", want.kept, got.kept);
          check_field("x_cells", $signed(want.x_cells), $signed(got.x_cells));
          check_field("y_cells", $signed(want.y_cells), $signed(got.y_cells));
          check_field("scan_end", want.scan_end, got.scan_end);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned tick;
    int unsigned hold_left;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (tick >= 6000 && tick < 10000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  function automatic void plan_write(logic [2:0] sel, logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.sel = sel;
    r.wdata = val;
    plan = {plan, r};
  endfunction

  function automatic void plan_beam(logic [RangeW-1:0] rng, logic first, logic last);
    plan_row_t r;
    r = '0;
    r.beat.range_sample = rng;
    r.beat.first_beam = first;
    r.beat.last_beam = last;
    plan = {plan, r};
  endfunction

  function automatic void plan_origin(logic [RangeW-1:0] rng, logic first, logic last,
                                      logic kept);
    plan_row_t r;
    r = '0;
    r.beat.range_sample = rng;
    r.beat.first_beam = first;
    r.beat.last_beam = last;
    r.fixed = 1'b1;
    r.want.kept = kept;
    r.want.scan_end = last;
    plan = {plan, r};
  endfunction

  function automatic logic [RangeW-1:0] pick_range();
    int lo, hi;
    lo = int'(shadow.min_range);
    hi = int'(shadow.max_range) - MARGIN_Q12;
    case ($urandom_range(4, 0))
      0: return RangeW'($urandom());
      1: return RangeW'(lo + int'($urandom_range(2, 0)) - 1);
      2: return RangeW'(hi + int'($urandom_range(3, 0)) - 2);
      default: begin
        if (hi > lo) return RangeW'(lo + int'($urandom_range(hi - lo, 0)));
        return RangeW'($urandom());
      end
    endcase
  endfunction

  task automatic send_beam(in_beat_t b, logic fixed, out_beat_t want);
    while (!sender_calm && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    in_fixed <= fixed;
    in_fixed_beat <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait for every beat to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic reg_write(logic [2:0] sel, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic bus_release();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    bit          bus_held;
    bit          noisy;
    int          sent;
    int          len;
    logic [31:0] step_v, min_v, max_v, scale_v;
    in_beat_t    b;

    plan_origin(20'd0, 1'b1, 1'b0, 1'b0);
    plan_beam(20'd1, 1'b0, 1'b0);
    plan_beam(20'hFFFFF - 20'd411, 1'b0, 1'b0);
    plan_origin(20'hFFFFF - 20'd410, 1'b0, 1'b1, 1'b0);
    plan_origin(20'hFFFFF, 1'b0, 1'b0, 1'b0);
    plan_write(REG_START_ANGLE, 32'hABCD_E000);
    plan_write(REG_ANGLE_STEP, 32'h0000_4000);
    plan_write(REG_SPARE, 32'hFFFF_FFFF);
    plan_write(REG_MIN_RANGE, 32'h0000_0400);
    plan_write(REG_MAX_RANGE, 32'hFFF5_0000);
    for (int k = 0; k < 5; k++) plan_beam(20'd40960, k == 0, k == 4);
    plan_origin(20'd1024, 1'b0, 1'b0, 1'b0);
    plan_beam(20'd1025, 1'b0, 1'b0);
    plan_write(REG_START_ANGLE, 32'h0000_8000);
    plan_write(REG_ANGLE_STEP, 32'h0000_7FFF);
    plan_write(REG_MAX_RANGE, 32'h000F_FFFF);
    plan_write(REG_SCALE, 32'h00FF_FFFF);
    for (int k = 0; k < 3; k++) plan_beam(20'hFFFFF - 20'd411, k == 0, 1'b0);
    plan_write(REG_START_ANGLE, 32'h0000_7FFF);
    plan_write(REG_ANGLE_STEP, 32'h0000_8000);
    plan_write(REG_SCALE, 32'h0000_0000);
    plan_origin(20'd5000, 1'b1, 1'b0, 1'b1);
    plan_origin(20'd0, 1'b0, 1'b1, 1'b0);
    plan_write(REG_MIN_RANGE, 32'h000F_FFFF);
    plan_write(REG_MAX_RANGE, 32'h0000_0000);
    plan_origin(20'hFFFFF, 1'b1, 1'b1, 1'b0);
    plan_origin(20'd12345, 1'b0, 1'b0, 1'b0);
    plan_write(REG_MIN_RANGE, 32'd0);
    plan_write(REG_MAX_RANGE, 32'd410);
    plan_write(REG_SCALE, 32'd2621440);
    plan_origin(20'd1, 1'b0, 1'b0, 1'b0);
    plan_write(REG_MAX_RANGE, 32'd412);
    plan_beam(20'd1, 1'b0, 1'b0);
    plan_origin(20'd2, 1'b0, 1'b1, 1'b0);

    do @(posedge clk); while (!rst_n);

    bus_held = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!bus_held) drain();
        reg_write(plan[i].sel, plan[i].wdata);
        bus_held = 1'b1;
      end else begin
        if (bus_held) bus_release();
        bus_held = 1'b0;
        send_beam(plan[i].beat, plan[i].fixed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      step_v  = (p == 0) ? 32'h7FFF : (p == 1) ? 32'h8000 :
                (p == 2) ? $urandom_range(64, 1) : $urandom();
      min_v   = (p == 0) ? 32'd0 : $urandom_range(8192, 0);
      max_v   = (p == 0) ? 32'hFFFFF : $urandom_range(32'hFFFFF, 32'hA0000);
      scale_v = (p == 0) ? 32'hFFFFFF : (p == 1) ? $urandom_range(32'h0FFFFF, 0) :
                (p == 5) ? $urandom() : $urandom_range(32'h400000, 32'h080000);
      reg_write(REG_START_ANGLE, (p == 1) ? 32'h7FFF : $urandom());
      reg_write(REG_ANGLE_STEP, step_v);
      reg_write(REG_MIN_RANGE, min_v);
      reg_write(REG_MAX_RANGE, max_v);
      reg_write(REG_SCALE, scale_v);
      bus_release();
      sender_calm = (p == 2);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        noisy = ($urandom_range(9, 0) == 0);
        len = noisy ? 1 : $urandom_range(48, 1);
        for (int k = 0; k < len; k++) begin
          b.range_sample = noisy ? RangeW'($urandom()) : pick_range();
          b.first_beam = noisy ? 1'($urandom()) : (k == 0);
          b.last_beam = noisy ? 1'($urandom()) : (k == len - 1);
          send_beam(b, 1'b0, '0);
          sent++;
          // hold off the receiver so the core backs up
          if (p == 3 && sent == 40) hold_request = 1'b1;
        end
      end
      sender_calm = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lsp_pkg.sv
sv/lsp_ctrl.sv
sv/lsp_dp.sv
sv/laser_scan_polar_to_cartesian_core.sv
verif/testbench.sv
